>>> hdl/k_transaction_max_profit_defines.svh
// ---------------------------------------------------------------------------
// k_transaction_max_profit_defines : assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef K_TRANSACTION_MAX_PROFIT_DEFINES_SVH
`define K_TRANSACTION_MAX_PROFIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define KT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("k_transaction_max_profit assertion failed");
// next-cycle implication
`define KT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("k_transaction_max_profit assertion failed");
`else
`define KT_ASSERT_NOW(lbl, ante, cons)
`define KT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/ktmp_pkg.sv
// ---------------------------------------------------------------------------
// ktmp_pkg : shared types and constants
// Field widths, row constants and the controller-to-datapath command struct.
// ---------------------------------------------------------------------------
package ktmp_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 31;
  localparam int VAL_W    = 32;
  localparam int TRADES_W = 6;

  // holding value before any buy: -2^30
  localparam logic signed [VAL_W-1:0] HOLD_INIT = -(32'sd1 <<< 30);
  // flat profit saturation point, in the widened sum width
  localparam logic signed [VAL_W:0]   PROFIT_MAX = 33'sh0_7FFF_FFFF;

  typedef struct packed {
    logic cfg_wr;   // write max_trades
    logic step;     // update the row with the current price
    logic finish;   // load result register and clear the row
  } dp_cmd_t;

endpackage

>>> hdl/ktmp_datapath.sv
// ---------------------------------------------------------------------------
// ktmp_datapath : profit row and result register
// Holds the flat/holding row for every trade count, updates all cells in
// parallel per price, and reads out the configured count on finish.
// ---------------------------------------------------------------------------
module ktmp_datapath import ktmp_pkg::*; #(
  parameter int MAX_TRADES_BOUND = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  input  logic [TRADES_W-1:0] cfg_data,
  input  logic [PRICE_W-1:0]  price,
  output logic [PROFIT_W-1:0] profit
);

  localparam int Depth = MAX_TRADES_BOUND + 1;
  localparam int IdxW  = $clog2(Depth);

  logic [TRADES_W-1:0]     max_trades;
  logic signed [VAL_W-1:0] flat_row [Depth];
  logic signed [VAL_W-1:0] hold_row [Depth];
  logic signed [VAL_W-1:0] flat_next [Depth];
  logic signed [VAL_W-1:0] hold_next [Depth];
  logic signed [VAL_W:0]   price_s;
  logic [IdxW-1:0]         sel_idx;
  logic signed [VAL_W-1:0] sel_flat;

  assign price_s = {{(VAL_W+1-PRICE_W){1'b0}}, price};

  // next row from the previous day's values, one cell per trade count
  always_comb begin
    logic signed [VAL_W:0] buy_c;
    logic signed [VAL_W:0] sell_c;
    buy_c = -price_s;
    hold_next[0] = (buy_c > (VAL_W+1)'(hold_row[0])) ? buy_c[VAL_W-1:0] : hold_row[0];
    flat_next[0] = flat_row[0];
    for (int j = 1; j < Depth; j++) begin
      buy_c  = (VAL_W+1)'(flat_row[j]) - price_s;
      sell_c = (VAL_W+1)'(hold_row[j-1]) + price_s;
      if (sell_c > PROFIT_MAX) begin
        sell_c = PROFIT_MAX;
      end
      hold_next[j] = (buy_c > (VAL_W+1)'(hold_row[j])) ? buy_c[VAL_W-1:0] : hold_row[j];
      flat_next[j] = (sell_c > (VAL_W+1)'(flat_row[j])) ? sell_c[VAL_W-1:0] : flat_row[j];
    end
  end

  // limit clamped to the row depth
  always_comb begin
    if (int'(max_trades) > MAX_TRADES_BOUND) begin
      sel_idx = IdxW'(MAX_TRADES_BOUND);
    end else begin
      sel_idx = IdxW'(max_trades);
    end
  end

  assign sel_flat = flat_row[sel_idx];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_trades <= TRADES_W'(2);
    end else if (cmd.cfg_wr) begin
      max_trades <= cfg_data;
    end
  end

  // row update and clear
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int j = 0; j < Depth; j++) begin
        flat_row[j] <= '0;
        hold_row[j] <= HOLD_INIT;
      end
    end else if (cmd.step) begin
      for (int j = 0; j < Depth; j++) begin
        flat_row[j] <= flat_next[j];
        hold_row[j] <= hold_next[j];
      end
    end
  end

  // result register, negative values read as zero
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      profit <= sel_flat[VAL_W-1] ? '0 : sel_flat[PROFIT_W-1:0];
    end
  end

endmodule

>>> hdl/ktmp_ctrl.sv
// ---------------------------------------------------------------------------
// ktmp_ctrl : sequence controller
// Steps the row on every accepted price and, after the last one, waits for
// a free output slot to emit the result.
// ---------------------------------------------------------------------------
module ktmp_ctrl import ktmp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    last_day,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  output dp_cmd_t cmd
);

  localparam logic S_RUN = 1'b0;
  localparam logic S_FIN = 1'b1;

  logic state;
  logic state_next;
  logic in_beat;
  logic slot_free;

  assign in_ready  = (state == S_RUN);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // commands
  always_comb begin
    cmd.cfg_wr = cfg_valid;
    cmd.step   = in_beat;
    cmd.finish = (state == S_FIN) && slot_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: if (in_beat && last_day) state_next = S_FIN;
      S_FIN: if (slot_free) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  // output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/k_transaction_max_profit.sv
// ---------------------------------------------------------------------------
// k_transaction_max_profit : best profit from at most k buy-sell pairs
// Price sequence in, one saturated profit out after the last price.
// ---------------------------------------------------------------------------
//  channel  signals                          beat carries
//  in       in_valid / in_ready              price, last_day
//  out      out_valid / out_ready            profit
//  cfg      cfg_valid / cfg_ready            cfg_data -> max_trades
//
//  Prices are taken back to back; each updates the whole row of trade counts in parallel.
//  After a last_day beat a finish state loads the result register and clears
//  the row; it stalls there while a previous result has not been taken.
//  Reset is synchronous; it clears the row and sets max_trades to 2.
// ---------------------------------------------------------------------------
`include "k_transaction_max_profit_defines.svh"

module k_transaction_max_profit import ktmp_pkg::*; #(
  parameter int MAX_TRADES_BOUND = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PRICE_W-1:0]  price,
  input  logic                last_day,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PROFIT_W-1:0] profit,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TRADES_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  ktmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_day  (last_day),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  ktmp_datapath #(
    .MAX_TRADES_BOUND (MAX_TRADES_BOUND)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_data (cfg_data),
    .price    (price),
    .profit   (profit)
  );

  // a last beat always moves to the finish cycle
  `KT_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && last_day, !in_ready)
  // finish with an empty output slot completes at once
  `KT_ASSERT_NEXT(a_fin_empty, !in_ready && !out_valid, out_valid && in_ready)
  // a result only appears out of the finish cycle
  `KT_ASSERT_NOW(a_rise_from_fin, $rose(out_valid), $past(!in_ready))

endmodule
